// ===== rtl/core/i2cmrt_pkg.sv =====
// Shared types and constants for the I2C master register transfer block.
// No dependencies; used by i2cmrt_core and i2c_master_register_transfer.
`timescale 1ns / 1ps
`default_nettype none

package i2cmrt_pkg;

    // Input opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_BYTE  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_DATA_SETUP  = 2'd1;
    localparam logic [1:0] REG_DATA_TAIL   = 2'd2;
    localparam logic [1:0] REG_POLL_LIMIT  = 2'd3;

    // Configuration reset values
    localparam logic [7:0] HALF_PERIOD_RST = 8'd5;
    localparam logic [7:0] DATA_SETUP_RST  = 8'd2;
    localparam logic [7:0] DATA_TAIL_RST   = 8'd3;
    localparam logic [7:0] POLL_LIMIT_RST  = 8'd50;

    typedef struct packed {
        logic [7:0] half_period_ticks;
        logic [7:0] data_setup_ticks;
        logic [7:0] data_tail_ticks;
        logic [7:0] ack_poll_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       read_last;
        logic       write_byte_wanted;
        logic       busy_res;
        logic       done_res;
        logic       status;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2c_master_register_transfer.sv =====
// I2C master register transfer: top level with input register, result register
// and configuration registers. Depends on i2cmrt_pkg and i2cmrt_core.
//
// Each input transfer is one bus timing tick; one tick is accepted every clock
// cycle while results are taken; each tick yields exactly one result transfer,
// via the input register, then the result register. The sequencer state advances
// only when a registered tick moves into the result register, so back-pressure on
// the result side stalls the bus timing but loses nothing. op 1/2 start a write or
// read transaction while idle; op 3 supplies a data byte when write_byte_wanted is
// shown. Configuration writes are taken at any time but should be made while idle.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_register_transfer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // tick input
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_op,
    input  wire logic [7:0] s_device_address,
    input  wire logic [7:0] s_register_address,
    input  wire logic [7:0] s_byte_count,
    input  wire logic [7:0] s_write_byte,
    input  wire logic       s_sda_in,
    // tick result
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_scl_level,
    output logic            m_sda_level,
    output logic            m_sda_drive,
    output logic [7:0]      m_read_byte,
    output logic            m_read_valid,
    output logic            m_read_last,
    output logic            m_write_byte_wanted,
    output logic            m_busy_res,
    output logic            m_done_res,
    output logic            m_status,
    // configuration
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_wdata
);

    i2cmrt_pkg::cfg_t  cfg_reg;
    i2cmrt_pkg::item_t item_reg;
    i2cmrt_pkg::res_t  res_reg;
    i2cmrt_pkg::res_t  res_comb;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period_ticks <= i2cmrt_pkg::HALF_PERIOD_RST;
            cfg_reg.data_setup_ticks  <= i2cmrt_pkg::DATA_SETUP_RST;
            cfg_reg.data_tail_ticks   <= i2cmrt_pkg::DATA_TAIL_RST;
            cfg_reg.ack_poll_limit    <= i2cmrt_pkg::POLL_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                i2cmrt_pkg::REG_HALF_PERIOD: cfg_reg.half_period_ticks <= cfg_wdata;
                i2cmrt_pkg::REG_DATA_SETUP:  cfg_reg.data_setup_ticks  <= cfg_wdata;
                i2cmrt_pkg::REG_DATA_TAIL:   cfg_reg.data_tail_ticks   <= cfg_wdata;
                i2cmrt_pkg::REG_POLL_LIMIT:  cfg_reg.ack_poll_limit    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.op               <= s_op;
            item_reg.device_address   <= s_device_address;
            item_reg.register_address <= s_register_address;
            item_reg.byte_count       <= s_byte_count;
            item_reg.write_byte       <= s_write_byte;
            item_reg.sda_in           <= s_sda_in;
        end
    end

    i2cmrt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .res     (res_comb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_comb;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_scl_level         = res_reg.scl_level;
    assign m_sda_level         = res_reg.sda_level;
    assign m_sda_drive         = res_reg.sda_drive;
    assign m_read_byte         = res_reg.read_byte;
    assign m_read_valid        = res_reg.read_valid;
    assign m_read_last         = res_reg.read_last;
    assign m_write_byte_wanted = res_reg.write_byte_wanted;
    assign m_busy_res          = res_reg.busy_res;
    assign m_done_res          = res_reg.done_res;
    assign m_status            = res_reg.status;

endmodule

`default_nettype wire

// ===== rtl/core/i2cmrt_core.sv =====
// Bus sequencer: transaction state registers and the per-tick next-state logic.
// Depends on i2cmrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cmrt_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire i2cmrt_pkg::item_t item,
    input  wire i2cmrt_pkg::cfg_t  cfg,
    output i2cmrt_pkg::res_t      res
);

    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_START_A   = 5'd1;
    localparam logic [4:0] PH_START_B   = 5'd2;
    localparam logic [4:0] PH_BIT_SETUP = 5'd3;
    localparam logic [4:0] PH_BIT_HIGH  = 5'd4;
    localparam logic [4:0] PH_BIT_TAIL  = 5'd5;
    localparam logic [4:0] PH_ACK_WAIT  = 5'd6;
    localparam logic [4:0] PH_ACK_HIGH  = 5'd7;
    localparam logic [4:0] PH_WAIT_BYTE = 5'd8;
    localparam logic [4:0] PH_RD_LOW    = 5'd9;
    localparam logic [4:0] PH_RD_HIGH   = 5'd10;
    localparam logic [4:0] PH_MACK_LOW  = 5'd11;
    localparam logic [4:0] PH_MACK_HIGH = 5'd12;
    localparam logic [4:0] PH_STOP_LOW  = 5'd13;
    localparam logic [4:0] PH_STOP_HIGH = 5'd14;

    // Byte stages within a transaction
    localparam logic [1:0] BS_DEVICE   = 2'd0;
    localparam logic [1:0] BS_REGISTER = 2'd1;
    localparam logic [1:0] BS_READ_ADR = 2'd2;
    localparam logic [1:0] BS_DATA     = 2'd3;

    logic [4:0] phase_reg,  phase_next;
    logic [7:0] tick_reg,   tick_next;
    logic [2:0] bit_reg,    bit_next;
    logic [7:0] shift_reg,  shift_next;
    logic [7:0] poll_reg,   poll_next;
    logic [7:0] bytes_reg,  bytes_next;
    logic       rmode_reg,  rmode_next;
    logic [7:0] taddr_reg,  taddr_next;
    logic [7:0] treg_reg,   treg_next;
    logic [1:0] stage_reg,  stage_next;
    logic       failed_reg, failed_next;

    logic [4:0] cur_phase;
    logic [7:0] cur_tick;
    logic [7:0] half_len;
    logic [7:0] setup_len;
    logic [8:0] len;
    logic       over;

    assign half_len  = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
    assign setup_len = (cfg.data_setup_ticks == 8'd0) ? 8'd1 : cfg.data_setup_ticks;

    always_comb begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        poll_next   = poll_reg;
        bytes_next  = bytes_reg;
        rmode_next  = rmode_reg;
        taddr_next  = taddr_reg;
        treg_next   = treg_reg;
        stage_next  = stage_reg;
        failed_next = failed_reg;
        res         = '0;

        // Commands are taken before the tick is worked
        if (phase_reg == PH_IDLE && (item.op == i2cmrt_pkg::OP_WRITE ||
                                     item.op == i2cmrt_pkg::OP_READ)) begin
            rmode_next  = (item.op == i2cmrt_pkg::OP_READ);
            taddr_next  = item.device_address;
            treg_next   = item.register_address;
            bytes_next  = item.byte_count;
            shift_next  = item.device_address;
            stage_next  = BS_DEVICE;
            failed_next = 1'b0;
            bit_next    = 3'd0;
            tick_next   = 8'd0;
            phase_next  = PH_START_A;
        end else if (phase_reg == PH_WAIT_BYTE && item.op == i2cmrt_pkg::OP_BYTE) begin
            shift_next = item.write_byte;
            bytes_next = bytes_reg - 8'd1;
            bit_next   = 3'd0;
            tick_next  = 8'd0;
            phase_next = PH_BIT_SETUP;
        end

        cur_phase = phase_next;
        cur_tick  = tick_next;

        unique case (cur_phase)
            PH_BIT_SETUP: len = {1'b0, setup_len};
            PH_BIT_TAIL:  len = {1'b0, cfg.data_tail_ticks};
            default:      len = {1'b0, half_len};
        endcase
        over = ({1'b0, cur_tick} + 9'd1) >= len;

        // Bus levels for this tick
        res.scl_level = 1'b1;
        res.sda_level = 1'b1;
        res.sda_drive = 1'b1;
        unique case (cur_phase)
            PH_START_B: res.sda_level = 1'b0;
            PH_BIT_SETUP, PH_BIT_TAIL: begin
                res.scl_level = 1'b0;
                res.sda_level = shift_next[7];
            end
            PH_BIT_HIGH: res.sda_level = shift_next[7];
            PH_ACK_WAIT, PH_RD_LOW: begin
                res.scl_level = 1'b0;
                res.sda_drive = 1'b0;
            end
            PH_WAIT_BYTE: begin
                res.scl_level         = 1'b0;
                res.sda_drive         = 1'b0;
                res.write_byte_wanted = 1'b1;
            end
            PH_ACK_HIGH, PH_RD_HIGH: res.sda_drive = 1'b0;
            PH_MACK_LOW: begin
                res.scl_level = 1'b0;
                res.sda_level = (bytes_next <= 8'd1);
            end
            PH_MACK_HIGH: res.sda_level = (bytes_next <= 8'd1);
            PH_STOP_LOW: begin
                res.scl_level = 1'b0;
                res.sda_level = 1'b0;
            end
            PH_STOP_HIGH: res.sda_level = 1'b0;
            default: ;
        endcase

        // Phase advance
        unique case (cur_phase)
            PH_START_A: begin
                tick_next = over ? 8'd0 : cur_tick + 8'd1;
                if (over) phase_next = PH_START_B;
            end
            PH_START_B: begin
                tick_next = over ? 8'd0 : cur_tick + 8'd1;
                if (over) begin
                    bit_next   = 3'd0;
                    phase_next = PH_BIT_SETUP;
                end
            end
            PH_BIT_SETUP: begin
                tick_next = over ? 8'd0 : cur_tick + 8'd1;
                if (over) phase_next = PH_BIT_HIGH;
            end
            PH_BIT_HIGH, PH_BIT_TAIL: begin
                tick_next = over ? 8'd0 : cur_tick + 8'd1;
                if (over) begin
                    if (cur_phase == PH_BIT_HIGH && cfg.data_tail_ticks != 8'd0) begin
                        phase_next = PH_BIT_TAIL;
                    end else if (bit_next != 3'd7) begin
                        bit_next   = bit_next + 3'd1;
                        shift_next = {shift_next[6:0], 1'b0};
                        phase_next = PH_BIT_SETUP;
                    end else begin
                        bit_next   = 3'd0;
                        poll_next  = 8'd0;
                        phase_next = PH_ACK_WAIT;
                    end
                end
            end
            PH_ACK_WAIT: begin
                tick_next = over ? 8'd0 : cur_tick + 8'd1;
                if (over) begin
                    if (!item.sda_in) begin
                        phase_next = PH_ACK_HIGH;
                    end else if (poll_next >= cfg.ack_poll_limit) begin
                        failed_next = 1'b1;
                        phase_next  = PH_STOP_LOW;
                    end else begin
                        poll_next = poll_next + 8'd1;
                    end
                end
            end
            PH_ACK_HIGH: begin
                tick_next = over ? 8'd0 : cur_tick + 8'd1;
                if (over) begin
                    bit_next = 3'd0;
                    case (stage_next)
                        BS_DEVICE: begin
                            shift_next = treg_next;
                            stage_next = BS_REGISTER;
                            phase_next = PH_BIT_SETUP;
                        end
                        BS_REGISTER: begin
                            if (rmode_next) begin
                                shift_next = taddr_next + 8'd1;
                                stage_next = BS_READ_ADR;
                                phase_next = PH_START_A;
                            end else begin
                                stage_next = BS_DATA;
                                phase_next = (bytes_next != 8'd0) ? PH_WAIT_BYTE
                                                                  : PH_STOP_LOW;
                            end
                        end
                        BS_READ_ADR:
                            phase_next = (bytes_next != 8'd0) ? PH_RD_LOW : PH_STOP_LOW;
                        default:
                            phase_next = (bytes_next != 8'd0) ? PH_WAIT_BYTE : PH_STOP_LOW;
                    endcase
                end
            end
            PH_RD_LOW: begin
                tick_next = over ? 8'd0 : cur_tick + 8'd1;
                if (over) phase_next = PH_RD_HIGH;
            end
            PH_RD_HIGH: begin
                // sample on the first tick with SCL high
                if (cur_tick == 8'd0) begin
                    shift_next = {shift_next[6:0], item.sda_in};
                    if (bit_next == 3'd7) begin
                        res.read_valid = 1'b1;
                        res.read_byte  = shift_next;
                        res.read_last  = (bytes_next == 8'd1);
                    end
                end
                tick_next = over ? 8'd0 : cur_tick + 8'd1;
                if (over) begin
                    if (bit_next != 3'd7) begin
                        bit_next   = bit_next + 3'd1;
                        phase_next = PH_RD_LOW;
                    end else begin
                        bit_next   = 3'd0;
                        phase_next = PH_MACK_LOW;
                    end
                end
            end
            PH_MACK_LOW: begin
                tick_next = over ? 8'd0 : cur_tick + 8'd1;
                if (over) phase_next = PH_MACK_HIGH;
            end
            PH_MACK_HIGH: begin
                tick_next = over ? 8'd0 : cur_tick + 8'd1;
                if (over) begin
                    bytes_next = bytes_next - 8'd1;
                    phase_next = (bytes_next != 8'd0) ? PH_RD_LOW : PH_STOP_LOW;
                end
            end
            PH_STOP_LOW: begin
                tick_next = over ? 8'd0 : cur_tick + 8'd1;
                if (over) phase_next = PH_STOP_HIGH;
            end
            PH_STOP_HIGH: begin
                tick_next = over ? 8'd0 : cur_tick + 8'd1;
                if (over) begin
                    phase_next   = PH_IDLE;
                    res.done_res = 1'b1;
                    res.status   = failed_next;
                end
            end
            PH_WAIT_BYTE: ;
            default: begin
                phase_next = PH_IDLE;
                tick_next  = 8'd0;
            end
        endcase

        res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= 8'd0;
            bit_reg    <= 3'd0;
            shift_reg  <= 8'd0;
            poll_reg   <= 8'd0;
            bytes_reg  <= 8'd0;
            rmode_reg  <= 1'b0;
            taddr_reg  <= 8'd0;
            treg_reg   <= 8'd0;
            stage_reg  <= BS_DEVICE;
            failed_reg <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            poll_reg   <= poll_next;
            bytes_reg  <= bytes_next;
            rmode_reg  <= rmode_next;
            taddr_reg  <= taddr_next;
            treg_reg   <= treg_next;
            stage_reg  <= stage_next;
            failed_reg <= failed_next;
        end
    end

endmodule

`default_nettype wire
